[hw/rtl/rsb_pkg.sv]
// shared types, constants and codes for the rle sprite blitter
package rsb_pkg;

  localparam int ADDR_BITS        = 20;
  localparam int BUFFER_ROW_PITCH = 768;
  localparam int WIDTH_BITS       = 10;
  localparam int RUN_BITS         = 7;
  localparam int CFG_DATA_BITS    = (ADDR_BITS > WIDTH_BITS) ? ADDR_BITS : WIDTH_BITS;
  localparam int CFG_INDEX_BITS   = 3;

  // input commands
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STREAM = 2'd1,
    CMD_LOAD   = 2'd2
  } cmd_t;

  // draw modes
  typedef enum logic [1:0] {
    MODE_COPY      = 2'd0,
    MODE_TRANSLATE = 2'd1,
    MODE_STIPPLE   = 2'd2,
    MODE_OUTLINE   = 2'd3
  } draw_mode_t;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_ADDRESS = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPRITE_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAW_MODE     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTLINE_COLOR = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_LOW      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_HIGH     = 3'd5;

  // configuration register file contents
  typedef struct packed {
    logic [ADDR_BITS-1:0]  start_address;
    logic [WIDTH_BITS-1:0] sprite_width;
    draw_mode_t            draw_mode;
    logic [7:0]            outline_color;
    logic [ADDR_BITS-1:0]  clip_low;
    logic [ADDR_BITS-1:0]  clip_high;
  } cfg_t;

  // write set handed from the decoder to the write sequencer
  typedef struct packed {
    logic                 valid;
    logic                 outline;
    logic                 use_table;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           value;
  } wr_req_t;

endpackage

[hw/rtl/rsb_color_table.sv]
// 256-entry color table with one write port and a registered read port
module rsb_color_table
  import rsb_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  logic [7:0] wr_index,
  input  logic [7:0] wr_data,
  input  logic       rd_en,
  input  logic [7:0] rd_index,
  output logic [7:0] rd_data
);

  logic [7:0] mem [256];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_index] <= wr_data;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_index];
    end
  end

endmodule

[hw/rtl/rsb_decoder.sv]
// run-length stream decoder: walk state and per-item write set
module rsb_decoder
  import rsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic [1:0] cmd,
  input  logic [7:0] data_byte,
  output wr_req_t    req,
  output logic       is_stream,
  output logic       is_load
);

  logic [ADDR_BITS-1:0]  current_address, current_address_next;
  logic [WIDTH_BITS-1:0] row_remaining, row_remaining_next;
  logic [RUN_BITS-1:0]   run_remaining, run_remaining_next;
  logic                  run_visible, run_visible_next;
  logic                  stipple_parity, stipple_parity_next;

  logic [ADDR_BITS-1:0]  row_back;
  logic [ADDR_BITS-1:0]  addr_step;
  logic [7:0]            take_amt;
  logic [WIDTH_BITS-1:0] row_left;
  logic                  in_clip;

  // saturating take of pixels from the row budget
  function automatic logic [WIDTH_BITS-1:0] row_take(input logic [WIDTH_BITS-1:0] row,
                                                     input logic [7:0] n);
    logic [WIDTH_BITS-1:0] n_ext;
    n_ext = WIDTH_BITS'(n);
    if (n_ext >= row) return '0;
    return row - n_ext;
  endfunction

  assign is_stream = (cmd == CMD_STREAM);
  assign is_load   = (cmd == CMD_LOAD);

  // shared row-end step back and header arithmetic
  assign row_back = ADDR_BITS'(BUFFER_ROW_PITCH) + ADDR_BITS'(cfg.sprite_width);
  assign take_amt = data_byte[7] ? (8'd0 - data_byte) : data_byte;
  assign row_left = row_take(row_remaining, take_amt);
  assign in_clip  = (current_address >= cfg.clip_low) && (current_address < cfg.clip_high);
  assign addr_step = (run_remaining != '0) ? (current_address + ADDR_BITS'(1))
                   : data_byte[7]          ? (current_address + ADDR_BITS'(take_amt))
                   :                         current_address;

  // next state and write set
  always_comb begin
    current_address_next = current_address;
    row_remaining_next   = row_remaining;
    run_remaining_next   = run_remaining;
    run_visible_next     = run_visible;
    stipple_parity_next  = stipple_parity;
    req.valid     = 1'b0;
    req.outline   = 1'b0;
    req.use_table = 1'b0;
    req.addr      = current_address;
    req.value     = data_byte;
    case (cmd)
      CMD_START: begin
        current_address_next = cfg.start_address;
        row_remaining_next   = cfg.sprite_width;
        run_remaining_next   = '0;
        run_visible_next     = 1'b0;
        stipple_parity_next  = cfg.start_address[0];
      end
      CMD_STREAM: begin
        if (run_remaining != '0) begin
          // pixel byte of a literal run
          if (run_visible) begin
            case (cfg.draw_mode)
              MODE_COPY: req.valid = 1'b1;
              MODE_TRANSLATE: begin
                req.valid     = 1'b1;
                req.use_table = 1'b1;
              end
              MODE_STIPPLE: begin
                req.valid     = (current_address[0] != stipple_parity);
                req.use_table = 1'b1;
              end
              MODE_OUTLINE: begin
                req.valid   = (data_byte != 8'd0);
                req.outline = 1'b1;
                req.value   = cfg.outline_color;
              end
              default: req.valid = 1'b0;
            endcase
          end
          run_remaining_next = run_remaining - RUN_BITS'(1);
          if (run_remaining == RUN_BITS'(1) && row_remaining == '0) begin
            current_address_next = addr_step - row_back;
            row_remaining_next   = cfg.sprite_width;
            stipple_parity_next  = ~stipple_parity;
          end else begin
            current_address_next = addr_step;
          end
        end else begin
          // run header: skip or literal
          if (!data_byte[7]) begin
            run_remaining_next = data_byte[RUN_BITS-1:0];
            run_visible_next   = (cfg.draw_mode == MODE_STIPPLE ||
                                  cfg.draw_mode == MODE_OUTLINE) ? 1'b1 : in_clip;
          end
          if (row_left == '0 && (data_byte[7] || data_byte == 8'd0)) begin
            current_address_next = addr_step - row_back;
            row_remaining_next   = cfg.sprite_width;
            stipple_parity_next  = ~stipple_parity;
          end else begin
            current_address_next = addr_step;
            row_remaining_next   = row_left;
          end
        end
      end
      default: begin
        // table loads and unknown commands leave the walk alone
      end
    endcase
  end

  // walk state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_address <= '0;
      row_remaining   <= '0;
      run_remaining   <= '0;
      run_visible     <= 1'b0;
      stipple_parity  <= 1'b0;
    end else if (take) begin
      current_address <= current_address_next;
      row_remaining   <= row_remaining_next;
      run_remaining   <= run_remaining_next;
      run_visible     <= run_visible_next;
      stipple_parity  <= stipple_parity_next;
    end
  end

endmodule

[hw/rtl/rsb_write_seq.sv]
// output register that plays out zero, one or four pixel writes per item
module rsb_write_seq
  import rsb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  wr_req_t              req,
  input  logic [7:0]           table_data,
  output logic                 accept_ok,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  output logic [ADDR_BITS-1:0] write_address,
  output logic [7:0]           pixel_value,
  output logic                 last
);

  logic [2:0]           count;
  logic [1:0]           step;
  logic                 outline;
  logic                 use_table;
  logic [ADDR_BITS-1:0] base_addr;
  logic [7:0]           value;
  logic [ADDR_BITS-1:0] offset;
  logic                 pix_xfer;

  assign pix_valid = (count != 3'd0);
  assign pix_xfer  = pix_valid && pix_ready;
  assign last      = (count == 3'd1);
  // room for a new item when nothing is pending or the last pending write ends in this cycle
  assign accept_ok = (count == 3'd0) || (last && pix_ready);

  // neighbor offset for outline writes
  always_comb begin
    case (step)
      2'd0:    offset = ADDR_BITS'(0) - ADDR_BITS'(BUFFER_ROW_PITCH);
      2'd1:    offset = ADDR_BITS'(0) - ADDR_BITS'(1);
      2'd2:    offset = ADDR_BITS'(1);
      default: offset = ADDR_BITS'(BUFFER_ROW_PITCH);
    endcase
  end

  assign write_address = outline ? (base_addr + offset) : base_addr;
  assign pixel_value   = use_table ? table_data : value;

  // write counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
      step  <= 2'd0;
    end else if (take) begin
      count <= req.valid ? (req.outline ? 3'd4 : 3'd1) : 3'd0;
      step  <= 2'd0;
    end else if (pix_xfer) begin
      count <= count - 3'd1;
      step  <= step + 2'd1;
    end
  end

  // write set payload
  always_ff @(posedge clk) begin
    if (take && req.valid) begin
      outline   <= req.outline;
      use_table <= req.use_table;
      base_addr <= req.addr;
      value     <= req.value;
    end
  end

endmodule

[hw/rtl/rle_sprite_blitter.sv]
// rle sprite blitter top level: config registers, decoder, color table, write sequencer
// Output: the first write of an item is offered in the cycle after its transfer.
// Throughput: one item per cycle in copy, translate and stippled modes when the output
// does not stall; an opaque pixel in outline mode holds the input while the write
// sequencer plays out its four neighbor writes, plus any output stall.
// Reset: synchronous; clears walk state, pending writes and config to defaults;
// the color table is not cleared and holds garbage until loaded.
module rle_sprite_blitter
  import rsb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [1:0]                cmd,
  input  logic [7:0]                data_byte,
  input  logic [7:0]                table_index,
  output logic                      pix_valid,
  input  logic                      pix_ready,
  output logic [ADDR_BITS-1:0]      write_address,
  output logic [7:0]                pixel_value,
  output logic                      last
);

  cfg_t       cfg;
  wr_req_t    req;
  logic       take;
  logic       is_stream;
  logic       is_load;
  logic [7:0] table_data;

  assign take = item_valid && item_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_address <= '0;
      cfg.sprite_width  <= WIDTH_BITS'(1);
      cfg.draw_mode     <= MODE_COPY;
      cfg.outline_color <= '0;
      cfg.clip_low      <= '0;
      cfg.clip_high     <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_START_ADDRESS: cfg.start_address <= cfg_data[ADDR_BITS-1:0];
        CFG_SPRITE_WIDTH:  cfg.sprite_width  <= cfg_data[WIDTH_BITS-1:0];
        CFG_DRAW_MODE:     cfg.draw_mode     <= draw_mode_t'(cfg_data[1:0]);
        CFG_OUTLINE_COLOR: cfg.outline_color <= cfg_data[7:0];
        CFG_CLIP_LOW:      cfg.clip_low      <= cfg_data[ADDR_BITS-1:0];
        CFG_CLIP_HIGH:     cfg.clip_high     <= cfg_data[ADDR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rsb_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .cmd       (cmd),
    .data_byte (data_byte),
    .req       (req),
    .is_stream (is_stream),
    .is_load   (is_load)
  );

  rsb_color_table u_table (
    .clk      (clk),
    .wr_en    (take && is_load),
    .wr_index (table_index),
    .wr_data  (data_byte),
    .rd_en    (take && is_stream),
    .rd_index (data_byte),
    .rd_data  (table_data)
  );

  rsb_write_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .req           (req),
    .table_data    (table_data),
    .accept_ok     (item_ready),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .write_address (write_address),
    .pixel_value   (pixel_value),
    .last          (last)
  );

endmodule

[hw/rtl/rsb_checker.sv]
// port-level assertions for the rle sprite blitter and their bind
module rsb_checker
  import rsb_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input logic [1:0]           cmd,
  input logic                 pix_valid,
  input logic                 pix_ready,
  input logic [ADDR_BITS-1:0] write_address,
  input logic [7:0]           pixel_value,
  input logic                 last
);

  // a stalled write stays offered
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid)
    else $error("write dropped while stalled");

  // a stalled write keeps its payload
  a_pix_stable: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> $stable(write_address) && $stable(pixel_value) &&
                                $stable(last))
    else $error("write payload changed while stalled");

  // no new item while a pending write is stalled
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |-> !item_ready)
    else $error("input taken while output stalled");

  // a non-stream transfer that drains the output leaves nothing behind
  a_quiet_cmd: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && cmd != CMD_STREAM && (!pix_valid || pix_ready)
    |=> !pix_valid)
    else $error("write appeared from a non-stream transfer");

  // nothing offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !pix_valid)
    else $error("write offered after reset");

endmodule

bind rle_sprite_blitter rsb_checker u_rsb_checker (.*);

[tb/rsb_pixel_checker.sv]
// pixel write checker for the rle sprite blitter: predicts writes per item and compares
module rsb_pixel_checker
  import rsb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      item_valid,
  input  logic                      item_ready,
  input  logic [1:0]                cmd,
  input  logic [7:0]                data_byte,
  input  logic [7:0]                table_index,
  input  logic                      pix_valid,
  input  logic                      pix_ready,
  input  logic [ADDR_BITS-1:0]      write_address,
  input  logic [7:0]                pixel_value,
  input  logic                      last,
  output int                        fail_count,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    addr_t      addr;
    logic [7:0] value;
    logic       last;
  } pix_write_t;

  // shadow of the configuration registers
  addr_t                 reg_start;
  logic [WIDTH_BITS-1:0] reg_width;
  draw_mode_t            reg_mode;
  logic [7:0]            reg_outline;
  addr_t                 reg_clip_lo;
  addr_t                 reg_clip_hi;

  // shadow of the sprite walk
  addr_t                 cur_addr;
  logic [WIDTH_BITS-1:0] row_left;
  logic [RUN_BITS-1:0]   run_left;
  logic                  run_shown;
  logic                  stip_par;
  logic [7:0]            palette [256];

  // writes still owed by the block, oldest first
  pix_write_t pending_writes [$];
  pix_write_t burst [4];
  int         burst_n;
  int         mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic stage_write(input addr_t a, input logic [7:0] v);
    burst[burst_n] = '{addr: a, value: v, last: 1'b0};
    burst_n++;
  endtask

  // row end: back to the row start, then one buffer row up
  task automatic close_row_if_done();
    if (row_left == '0) begin
      cur_addr = cur_addr - addr_t'(BUFFER_ROW_PITCH) - addr_t'(reg_width);
      row_left = reg_width;
      stip_par = ~stip_par;
    end
  endtask

  task automatic take_from_row(input logic [8:0] n);
    row_left = ({1'b0, n} >= row_left) ? '0 : row_left - WIDTH_BITS'(n);
  endtask

  // expected writes of one accepted item
  task automatic predict_writes(input logic [1:0] c, input logic [7:0] b,
                                input logic [7:0] ix);
    addr_t      a;
    logic [8:0] skip;
    pix_write_t w;
    burst_n = 0;
    case (c)
      CMD_START: begin
        cur_addr  = reg_start;
        row_left  = reg_width;
        run_left  = '0;
        run_shown = 1'b0;
        stip_par  = reg_start[0];
      end
      CMD_LOAD: palette[ix] = b;
      CMD_STREAM: begin
        if (run_left != '0) begin
          // pixel byte of the open run
          a = cur_addr;
          if (run_shown) begin
            case (reg_mode)
              MODE_COPY:      stage_write(a, b);
              MODE_TRANSLATE: stage_write(a, palette[b]);
              MODE_STIPPLE: begin
                if (a[0] != stip_par) stage_write(a, palette[b]);
              end
              default: begin
                if (b != 8'h00) begin
                  stage_write(a - addr_t'(BUFFER_ROW_PITCH), reg_outline);
                  stage_write(a - addr_t'(1), reg_outline);
                  stage_write(a + addr_t'(1), reg_outline);
                  stage_write(a + addr_t'(BUFFER_ROW_PITCH), reg_outline);
                end
              end
            endcase
          end
          cur_addr = a + addr_t'(1);
          run_left = run_left - 1'b1;
          if (run_left == '0) close_row_if_done();
        end else if (b[7]) begin
          // transparent skip
          skip = 9'd256 - {1'b0, b};
          cur_addr = cur_addr + addr_t'(skip);
          take_from_row(skip);
          close_row_if_done();
        end else begin
          // literal run header, clipped by its start address in copy and translate
          take_from_row({1'b0, b});
          run_left = b[RUN_BITS-1:0];
          if (reg_mode >= MODE_STIPPLE) run_shown = 1'b1;
          else run_shown = (cur_addr >= reg_clip_lo) && (cur_addr < reg_clip_hi);
          if (b == 8'h00) close_row_if_done();
        end
      end
      default: ;
    endcase
    for (int i = 0; i < burst_n; i++) begin
      w = burst[i];
      w.last = (i == burst_n - 1);
      pending_writes.push_back(w);
    end
  endtask

  // watch config, write and item transfers
  always @(posedge clk) begin
    pix_write_t w;
    if (rst) begin
      reg_start   = '0;
      reg_width   = WIDTH_BITS'(1);
      reg_mode    = MODE_COPY;
      reg_outline = '0;
      reg_clip_lo = '0;
      reg_clip_hi = '1;
      cur_addr    = '0;
      row_left    = '0;
      run_left    = '0;
      run_shown   = 1'b0;
      stip_par    = 1'b0;
      pending_writes.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_START_ADDRESS: reg_start   = cfg_data[ADDR_BITS-1:0];
          CFG_SPRITE_WIDTH:  reg_width   = cfg_data[WIDTH_BITS-1:0];
          CFG_DRAW_MODE:     reg_mode    = draw_mode_t'(cfg_data[1:0]);
          CFG_OUTLINE_COLOR: reg_outline = cfg_data[7:0];
          CFG_CLIP_LOW:      reg_clip_lo = cfg_data[ADDR_BITS-1:0];
          CFG_CLIP_HIGH:     reg_clip_hi = cfg_data[ADDR_BITS-1:0];
          default: ;
        endcase
      end
      // write transfer against the oldest expected write
      if (pix_valid && pix_ready) begin
        if (pending_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write addr %h value %h last %b",
                                    write_address, pixel_value, last));
        end else begin
          w = pending_writes.pop_front();
          if (write_address !== w.addr)
            report_mismatch($sformatf("write_address got %h expected %h",
                                      write_address, w.addr));
          if (pixel_value !== w.value)
            report_mismatch($sformatf("pixel_value got %h expected %h at %h",
                                      pixel_value, w.value, w.addr));
          if (last !== w.last)
            report_mismatch($sformatf("last got %b expected %b at %h",
                                      last, w.last, w.addr));
        end
      end
      if (item_valid && item_ready) predict_writes(cmd, data_byte, table_index);
    end
    outstanding <= pending_writes.size();
  end

endmodule

[tb/tb_rle_sprite_blitter.sv]
// testbench top for the rle sprite blitter: clock, reset, stimulus and verdict
module tb_rle_sprite_blitter
  import rsb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [ADDR_BITS-1:0] addr_t;

  localparam logic [1:0] CMD_UNKNOWN     = 2'd3;
  localparam int         NUM_PHASES      = 10;
  localparam int         ITEMS_PER_PHASE = 37;
  localparam int         CYCLE_LIMIT     = 300000;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      cfg_write   = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;
  logic                      item_valid  = 1'b0;
  logic                      item_ready;
  logic [1:0]                cmd         = '0;
  logic [7:0]                data_byte   = '0;
  logic [7:0]                table_index = '0;
  logic                      pix_valid;
  logic                      pix_ready   = 1'b0;
  logic [ADDR_BITS-1:0]      write_address;
  logic [7:0]                pixel_value;
  logic                      last;
  int                        fail_count;
  int                        outstanding;

  // stimulus bookkeeping
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         phase_items   = 0;
  int         run_track     = 0;
  int         cycles        = 0;
  draw_mode_t cur_mode      = MODE_COPY;
  logic [7:0] loaded_idx [$];
  bit         loaded_map [256];

  rle_sprite_blitter uut (.*);
  rsb_pixel_checker  chk (.*);

  // clock, period 12 ns
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stalls
  always @(posedge clk) begin
    pix_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one item transfer, with an optional idle gap before it
  task automatic send_item(input logic [1:0] c, input logic [7:0] b, input logic [7:0] ix);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    item_valid  <= 1'b1;
    cmd         <= c;
    data_byte   <= b;
    table_index <= ix;
    do @(posedge clk); while (!item_ready);
    if (c != CMD_UNKNOWN) phase_items++;
  endtask

  // stream byte; pixels in table modes only index loaded entries
  task automatic send_stream(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (run_track > 0) begin
      if (cur_mode == MODE_TRANSLATE || cur_mode == MODE_STIPPLE)
        v = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
      run_track--;
    end else if (!v[7]) begin
      run_track = v;
    end
    send_item(CMD_STREAM, v, 8'($urandom));
  endtask

  task automatic send_start();
    send_item(CMD_START, 8'($urandom), 8'($urandom));
    run_track = 0;
  endtask

  task automatic send_load(input logic [7:0] ix, input logic [7:0] v);
    if (!loaded_map[ix]) begin
      loaded_map[ix] = 1'b1;
      loaded_idx.push_back(ix);
    end
    send_item(CMD_LOAD, v, ix);
  endtask

  function automatic logic [7:0] pixel_byte();
    if ($urandom_range(0, 99) < 20) return 8'h00;
    return 8'($urandom);
  endfunction

  // stop sending and let every expected write drain
  task automatic wait_drained(input int extra);
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] ix,
                           input logic [CFG_DATA_BITS-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // register setting and idling profile of one phase
  task automatic set_phase(input int p);
    addr_t           st, lo, hi;
    logic [WIDTH_BITS-1:0] w;
    draw_mode_t      m;
    logic [7:0]      oc;
    st = addr_t'($urandom);
    w  = WIDTH_BITS'($urandom_range(1, 16));
    oc = 8'($urandom);
    lo = '0;
    hi = '1;
    case (p)
      0: begin m = MODE_COPY; st = '0; w = '1; end
      1: begin m = MODE_TRANSLATE; st = '1; w = WIDTH_BITS'(5); end
      2: begin m = MODE_STIPPLE; w = '0; end
      3: begin m = MODE_OUTLINE; st = addr_t'(BUFFER_ROW_PITCH); oc = 8'hFF; end
      4: begin m = MODE_COPY; lo = st - addr_t'(40); hi = st + addr_t'(20); end
      5: begin m = MODE_TRANSLATE; w = WIDTH_BITS'(1); lo = st; hi = st + addr_t'(30); end
      6: begin m = MODE_STIPPLE; st[0] = 1'b1; w = WIDTH_BITS'($urandom_range(2, 30)); end
      7: begin m = MODE_OUTLINE; st = '0; w = WIDTH_BITS'(3); oc = 8'h00; end
      8: begin m = MODE_TRANSLATE; lo = addr_t'($urandom); hi = addr_t'($urandom); end
      default: begin m = MODE_COPY; st = '1; w = WIDTH_BITS'(2); lo = '1; hi = '0; end
    endcase
    write_reg(CFG_START_ADDRESS, CFG_DATA_BITS'(st));
    write_reg(CFG_SPRITE_WIDTH, CFG_DATA_BITS'(w));
    write_reg(CFG_DRAW_MODE, CFG_DATA_BITS'(m));
    write_reg(CFG_OUTLINE_COLOR, CFG_DATA_BITS'(oc));
    write_reg(CFG_CLIP_LOW, CFG_DATA_BITS'(lo));
    write_reg(CFG_CLIP_HIGH, CFG_DATA_BITS'(hi));
    cfg_write <= 1'b0;
    cur_mode = m;
    case (p % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 45; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 45; end
      default: begin send_idle_pct = 16; stall_pct = 16; end
    endcase
  endtask

  // one random sequence: mostly well-formed runs, some noise and cut runs
  task automatic random_sequence();
    int r, n, k;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_start();
    end else if (r < 16) begin
      send_load(8'($urandom), 8'($urandom));
    end else if (r < 19) begin
      send_item(CMD_UNKNOWN, 8'($urandom), 8'($urandom));
    end else if (r < 26) begin
      send_stream(8'($urandom));
    end else if (r < 34) begin
      // run cut short by a new sprite
      n = $urandom_range(1, 127);
      k = $urandom_range(0, (n < 6) ? n - 1 : 5);
      send_stream(8'(n));
      repeat (k) send_stream(pixel_byte());
      send_start();
    end else if (r < 44) begin
      send_stream(8'($urandom_range(128, 255)));
    end else if (r < 47) begin
      send_stream(8'h00);
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_stream(8'(n));
      repeat (n) send_stream(pixel_byte());
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // stream before any start: header then pixel byte extremes
    send_stream(8'h03);
    send_stream(8'hFF);
    send_stream(8'h00);
    send_stream(8'hAA);
    // table loads at index and value extremes
    send_load(8'h00, 8'h00);
    send_load(8'hFF, 8'hFF);
    send_load(8'h55, 8'hAA);
    send_load(8'hAA, 8'h55);
    send_load(8'h01, 8'h80);
    send_item(CMD_UNKNOWN, 8'hFF, 8'hFF);
    send_start();
    // zero-length header, longest skip, shortest skip
    send_stream(8'h00);
    send_stream(8'h80);
    send_stream(8'hFF);
    // overlong run cut by a new sprite
    send_stream(8'h7F);
    send_stream(8'h01);
    send_stream(8'hFE);
    send_stream(8'h80);
    send_start();
    send_stream(8'h02);
    send_stream(8'h00);
    send_stream(8'hFF);

    // random phases, each with its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained(4);
      set_phase(p);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if (p == 3 && !paused && phase_items >= 20) begin
          wait_drained(0);
          paused = 1'b1;
        end
        random_sequence();
      end
    end

    wait_drained(8);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
